// File: sv/ovn_pkg.sv
// Shared types and constants for the octave value noise block.
// Holds field widths, command and register codes, and the structs passed
// between the walker, blend and accumulator stages. No dependencies.
`default_nettype none

package ovn_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned OCT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SUM_W      = 36;

  localparam logic [OCT_W-1:0] MAX_OCTAVES   = 5'd16;
  localparam logic [VAL_W-1:0] AMP_INIT      = 16'h8000;
  localparam logic [VAL_W-1:0] FALLOFF_INIT  = 16'h8000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_FALLOFF  = 4'd1;

  // Evaluation start: absolute coordinates, Q15.16
  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
    logic [COORD_W-1:0] mz;
  } start_t;

  // Lattice table write request
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } wr_req_t;

  // Lattice corner read result, tagged with corner number and fade weights
  typedef struct packed {
    logic             vld;
    logic [2:0]       corner;
    logic [VAL_W-1:0] wx;
    logic [VAL_W-1:0] wy;
    logic [VAL_W-1:0] wz;
    logic [VAL_W-1:0] data;
  } rd_item_t;

  // One Q0.16 value with a valid flag
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] value;
  } val_item_t;

endpackage

`default_nettype wire

// File: sv/ovn_if.sv
// Valid/ready channel interfaces for the octave value noise block.
// Input command channel, result channel and configuration write channel.
// Depends on ovn_pkg for field widths.
`default_nettype none

interface ovn_in_if import ovn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [IDX_W-1:0]          table_index;
  logic [VAL_W-1:0]          table_value;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, command, table_index, table_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, command, table_index, table_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface ovn_out_if import ovn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

interface ovn_cfg_if import ovn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/ovn_walker.sv
// Lattice table memory and octave walker: issues eight corner reads per
// octave from the single-port table and tags each read with its fade weights.
// Depends on ovn_pkg.
`default_nettype none

module ovn_walker import ovn_pkg::*; #(
  parameter int unsigned LATTICE_DEPTH    = 4096,
  parameter int unsigned Y_WRAP_SHIFT     = 4,
  parameter int unsigned Z_WRAP_SHIFT     = 8,
  parameter int unsigned FADE_TABLE_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire start_t           start,
  input  wire logic [OCT_W-1:0] count,
  input  wire wr_req_t          wr,
  output rd_item_t              rd,
  output logic                  busy
);

  localparam int unsigned ADDR_W  = $clog2(LATTICE_DEPTH);
  localparam int unsigned FIDX_W  = $clog2(FADE_TABLE_DEPTH);
  localparam int unsigned FPROD_W = FRAC_W + FIDX_W;

  localparam logic [ADDR_W-1:0] X_STEP = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] Y_STEP = ADDR_W'(1) << Y_WRAP_SHIFT;
  localparam logic [ADDR_W-1:0] Z_STEP = ADDR_W'(1) << Z_WRAP_SHIFT;

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] ANGLE_DIV = 64'(2 * FADE_TABLE_DEPTH);
  localparam logic [63:0] TAYLOR_DIV [1:7] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

  // sin^2 of a quarter turn scaled by idx, Taylor series in Q2.30
  function automatic logic [VAL_W-1:0] fade_weight(input int unsigned idx);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] f;
    logic [63:0] w;
    int          k;
    a    = (PI_Q30 * 64'(idx)) / ANGLE_DIV;
    a2   = (a * a) >> 30;
    term = a;
    s    = a;
    for (k = 1; k <= 7; k++) begin
      term = ((term * a2) >> 30) / TAYLOR_DIV[k];
      if (k[0]) begin
        s = (term > s) ? 64'd0 : s - term;
      end else begin
        s = s + term;
      end
    end
    f = (s * s) >> 30;
    w = (f + 64'd8192) >> 14;
    return (w > 64'd65535) ? {VAL_W{1'b1}} : w[VAL_W-1:0];
  endfunction

  // Fade ROM index: top fraction bits scaled to the ROM depth
  function automatic logic [FIDX_W-1:0] fade_index(input logic [FRAC_W-1:0] frac);
    logic [FPROD_W-1:0] p;
    p = FPROD_W'(frac) * FPROD_W'(FADE_TABLE_DEPTH);
    return p[FRAC_W +: FIDX_W];
  endfunction

  logic [VAL_W-1:0] fade_rom [FADE_TABLE_DEPTH];

  for (genvar i = 0; i < FADE_TABLE_DEPTH; i++) begin : g_fade_rom
    assign fade_rom[i] = fade_weight(i);
  end

  // Walker state
  logic              run_r;
  logic [2:0]        corner_r;
  logic [OCT_W-1:0]  left_r;
  logic [ADDR_W-1:0] xi_r, yi_r, zi_r;
  logic [FRAC_W-1:0] xf_r, yf_r, zf_r;

  // Read tag pipeline, aligned with the memory output register
  logic              tag_vld_r;
  logic [2:0]        tag_corner_r;
  logic [VAL_W-1:0]  tag_wx_r, tag_wy_r, tag_wz_r;
  logic [VAL_W-1:0]  mem_q_r;

  logic [VAL_W-1:0]  lattice_mem [LATTICE_DEPTH];

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] mem_addr;

  // Corner address: base offset plus the x, y and z steps of this corner
  always_comb begin
    base    = xi_r + ADDR_W'(yi_r << Y_WRAP_SHIFT) + ADDR_W'(zi_r << Z_WRAP_SHIFT);
    rd_addr = base + (corner_r[0] ? X_STEP : '0) + (corner_r[1] ? Y_STEP : '0)
                   + (corner_r[2] ? Z_STEP : '0);
    mem_addr = wr.vld ? ADDR_W'(wr.index) : rd_addr;
  end

  // Single-port table: write wins, otherwise read while walking
  always_ff @(posedge clk) begin
    if (wr.vld) begin
      lattice_mem[mem_addr] <= wr.value;
    end else if (run_r) begin
      mem_q_r <= lattice_mem[mem_addr];
    end
  end

  // Walk corners, then double the coordinates at the end of each octave
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      corner_r <= '0;
      left_r   <= '0;
    end else if (start.vld) begin
      run_r    <= 1'b1;
      corner_r <= '0;
      left_r   <= count;
    end else if (run_r) begin
      corner_r <= corner_r + 3'd1;
      if (corner_r == 3'd7) begin
        left_r <= left_r - OCT_W'(1);
        if (left_r == OCT_W'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.vld) begin
      xi_r <= start.mx[FRAC_W +: ADDR_W];
      yi_r <= start.my[FRAC_W +: ADDR_W];
      zi_r <= start.mz[FRAC_W +: ADDR_W];
      xf_r <= start.mx[FRAC_W-1:0];
      yf_r <= start.my[FRAC_W-1:0];
      zf_r <= start.mz[FRAC_W-1:0];
    end else if (run_r && corner_r == 3'd7) begin
      xi_r <= {xi_r[ADDR_W-2:0], xf_r[FRAC_W-1]};
      yi_r <= {yi_r[ADDR_W-2:0], yf_r[FRAC_W-1]};
      zi_r <= {zi_r[ADDR_W-2:0], zf_r[FRAC_W-1]};
      xf_r <= {xf_r[FRAC_W-2:0], 1'b0};
      yf_r <= {yf_r[FRAC_W-2:0], 1'b0};
      zf_r <= {zf_r[FRAC_W-2:0], 1'b0};
    end
  end

  // Tag each read with its corner and this octave's weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= run_r && !wr.vld;
    end
  end

  always_ff @(posedge clk) begin
    tag_corner_r <= corner_r;
    tag_wx_r     <= fade_rom[fade_index(xf_r)];
    tag_wy_r     <= fade_rom[fade_index(yf_r)];
    tag_wz_r     <= fade_rom[fade_index(zf_r)];
  end

  assign rd.vld    = tag_vld_r;
  assign rd.corner = tag_corner_r;
  assign rd.wx     = tag_wx_r;
  assign rd.wy     = tag_wy_r;
  assign rd.wz     = tag_wz_r;
  assign rd.data   = mem_q_r;
  assign busy      = run_r;

endmodule

`default_nettype wire

// File: sv/ovn_blend.sv
// Trilinear blend of the eight lattice corners of one octave.
// An x stage pairs corner reads, a shared y/z stage folds the pairs.
// Depends on ovn_pkg.
`default_nettype none

module ovn_blend import ovn_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rd_item_t rd,
  output val_item_t     oct
);

  // a + (b - a) * w, rounded, in Q0.16
  function automatic logic [VAL_W-1:0] lerp(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b,
                                            input logic [VAL_W-1:0] w);
    logic signed [VAL_W:0]     d;
    logic signed [2*VAL_W+1:0] acc;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    acc = $signed({2'b00, a, 1'b1, {(VAL_W-1){1'b0}}}) + d * $signed({1'b0, w});
    return acc[2*VAL_W-1:VAL_W];
  endfunction

  // X stage
  logic [VAL_W-1:0] lo_r;
  logic             xb_vld_r;
  logic [1:0]       xb_pair_r;
  logic [VAL_W-1:0] xb_r, xb_wy_r, xb_wz_r;

  // Y/Z stage
  logic [VAL_W-1:0] xlo_r, ylo_r, yhi_r, wz_r;
  logic             zpend_r;
  logic             oct_vld_r;
  logic [VAL_W-1:0] oct_r;

  logic [VAL_W-1:0] yz_a, yz_b, yz_w, yz_q;
  logic             y_fold;

  // Hold even corners, blend along x on odd corners
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xb_vld_r <= 1'b0;
    end else begin
      xb_vld_r <= rd.vld && rd.corner[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd.vld && !rd.corner[0]) begin
      lo_r <= rd.data;
    end
    if (rd.vld && rd.corner[0]) begin
      xb_r      <= lerp(lo_r, rd.data, rd.wx);
      xb_pair_r <= rd.corner[2:1];
      xb_wy_r   <= rd.wy;
      xb_wz_r   <= rd.wz;
    end
  end

  // Shared unit: y fold on odd x pairs, z fold the cycle after the upper plane
  assign y_fold = xb_vld_r && xb_pair_r[0];

  always_comb begin
    if (zpend_r) begin
      yz_a = ylo_r;
      yz_b = yhi_r;
      yz_w = wz_r;
    end else begin
      yz_a = xlo_r;
      yz_b = xb_r;
      yz_w = xb_wy_r;
    end
    yz_q = lerp(yz_a, yz_b, yz_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zpend_r   <= 1'b0;
      oct_vld_r <= 1'b0;
    end else begin
      zpend_r   <= y_fold && xb_pair_r[1];
      oct_vld_r <= zpend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (xb_vld_r && !xb_pair_r[0]) begin
      xlo_r <= xb_r;
    end
    if (y_fold && !xb_pair_r[1]) begin
      ylo_r <= yz_q;
    end
    if (y_fold && xb_pair_r[1]) begin
      yhi_r <= yz_q;
      wz_r  <= xb_wz_r;
    end
    if (zpend_r) begin
      oct_r <= yz_q;
    end
  end

  assign oct.vld   = oct_vld_r;
  assign oct.value = oct_r;

  // The z fold never collides with a y fold of the next octave
  a_yz_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(zpend_r && y_fold))
    else $error("y/z blend unit claimed twice in one cycle");

endmodule

`default_nettype wire

// File: sv/ovn_accum.sv
// Octave accumulator: weights each octave by its amplitude, sums in Q4.32,
// then rounds and saturates to Q0.16 and holds the result until taken.
// Depends on ovn_pkg.
`default_nettype none

module ovn_accum import ovn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start_vld,
  input  wire logic [OCT_W-1:0] count,
  input  wire logic [VAL_W-1:0] falloff,
  input  wire val_item_t        oct,
  input  wire logic             take,
  output val_item_t             res
);

  logic [VAL_W-1:0]   amp_r;
  logic [2*VAL_W-1:0] prod_r;
  logic               prod_vld_r;
  logic [SUM_W-1:0]   sum_r;
  logic [OCT_W-1:0]   left_r;
  logic               fin_r;
  logic               res_vld_r;
  logic [VAL_W-1:0]   res_r;

  logic [2*VAL_W-1:0] amp_prod;
  logic [SUM_W-1:0]   rnd;

  always_comb begin
    amp_prod = (2*VAL_W)'(amp_r) * (2*VAL_W)'(falloff) + (2*VAL_W)'(AMP_INIT);
    rnd      = sum_r + SUM_W'(AMP_INIT);
  end

  // Weight the octave and advance the amplitude
  always_ff @(posedge clk) begin
    if (start_vld) begin
      amp_r <= AMP_INIT;
    end else if (oct.vld) begin
      amp_r  <= amp_prod[2*VAL_W-1:VAL_W];
      prod_r <= (2*VAL_W)'(oct.value) * (2*VAL_W)'(amp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (start_vld) begin
      sum_r <= '0;
    end else if (prod_vld_r) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end
    if (fin_r) begin
      res_r <= (|rnd[SUM_W-1:2*VAL_W]) ? {VAL_W{1'b1}} : rnd[2*VAL_W-1:VAL_W];
    end
  end

  // Count octaves down, flag the final one, hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      left_r     <= '0;
      fin_r      <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      prod_vld_r <= oct.vld;
      fin_r      <= 1'b0;
      if (start_vld) begin
        left_r <= count;
        fin_r  <= (count == '0);
      end else if (prod_vld_r) begin
        left_r <= left_r - OCT_W'(1);
        fin_r  <= (left_r == OCT_W'(1));
      end
      if (fin_r) begin
        res_vld_r <= 1'b1;
      end else if (take) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  assign res.vld   = res_vld_r;
  assign res.value = res_r;

endmodule

`default_nettype wire

// File: sv/octave_value_noise_3d.sv
// Fractal 3D value noise over a lattice table; the octave count saturates at 16.
// The eight corner reads of each octave share the one table port, and the next
// item is taken only once the result moves to the output register, so evaluations
// never overlap; a table write is taken while no evaluation runs.
// Synchronous rst_n clears control, loads config defaults; table is undefined.
`default_nettype none

module octave_value_noise_3d import ovn_pkg::*; #(
  parameter int unsigned LATTICE_DEPTH    = 4096,
  parameter int unsigned Y_WRAP_SHIFT     = 4,
  parameter int unsigned Z_WRAP_SHIFT     = 8,
  parameter int unsigned FADE_TABLE_DEPTH = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ovn_in_if.sink    in_chan,
  ovn_out_if.source out_chan,
  ovn_cfg_if.sink   cfg_chan
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  function automatic logic [COORD_W-1:0] magnitude(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] m;
    if (v == {1'b1, {(COORD_W-1){1'b0}}}) begin
      m = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v[COORD_W-1]) begin
      m = ~v + COORD_W'(1);
    end else begin
      m = v;
    end
    return m;
  endfunction

  state_t             state_r, state_nxt;
  logic [OCT_W-1:0]   octave_count_r;
  logic [VAL_W-1:0]   falloff_r;
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_noise_r;

  logic               in_xfer;
  logic               cfg_xfer;
  logic [OCT_W-1:0]   count_sat;
  logic               out_free;
  logic               take;
  logic               walk_busy;
  start_t             start;
  start_t             walk_start;
  wr_req_t            wr;
  rd_item_t           rd;
  val_item_t          oct;
  val_item_t          res;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign cfg_xfer       = cfg_chan.valid && cfg_chan.ready;

  assign count_sat = (octave_count_r > MAX_OCTAVES) ? MAX_OCTAVES : octave_count_r;

  // Decode the input transfer into a table write or an evaluation start
  always_comb begin
    wr.vld       = in_xfer && (cmd_t'(in_chan.command) == CMD_WRITE);
    wr.index     = in_chan.table_index;
    wr.value     = in_chan.table_value;
    start.vld    = in_xfer && (cmd_t'(in_chan.command) == CMD_EVAL);
    start.mx     = magnitude(in_chan.coord_x);
    start.my     = magnitude(in_chan.coord_y);
    start.mz     = magnitude(in_chan.coord_z);
    walk_start     = start;
    walk_start.vld = start.vld && (count_sat != '0);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= MAX_OCTAVES;
      falloff_r      <= FALLOFF_INIT;
    end else if (cfg_xfer) begin
      case (cfg_chan.index)
        CFG_OCTAVE_COUNT: octave_count_r <= cfg_chan.data[OCT_W-1:0];
        CFG_AMP_FALLOFF:  falloff_r      <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Control: run an evaluation until its result moves to the output register
  assign out_free = !out_valid_r || out_chan.ready;
  assign take     = (state_r == ST_RUN) && res.vld && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start.vld) state_nxt = ST_RUN;
      ST_RUN:  if (take)      state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_noise_r <= res.value;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.noise_value = out_noise_r;

  ovn_walker #(
    .LATTICE_DEPTH    (LATTICE_DEPTH),
    .Y_WRAP_SHIFT     (Y_WRAP_SHIFT),
    .Z_WRAP_SHIFT     (Z_WRAP_SHIFT),
    .FADE_TABLE_DEPTH (FADE_TABLE_DEPTH)
  ) u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (walk_start),
    .count (count_sat),
    .wr    (wr),
    .rd    (rd),
    .busy  (walk_busy)
  );

  ovn_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rd),
    .oct   (oct)
  );

  ovn_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_vld (start.vld),
    .count     (count_sat),
    .falloff   (falloff_r),
    .oct       (oct),
    .take      (take),
    .res       (res)
  );

  a_res_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> state_r == ST_RUN)
    else $error("accumulator result pending outside an evaluation");

  a_walk_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    walk_busy |-> state_r == ST_RUN)
    else $error("table walker active outside an evaluation");

  a_no_write_while_walking: assert property (@(posedge clk) disable iff (!rst_n)
    wr.vld |-> !walk_busy)
    else $error("table write collides with a corner read");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for octave_value_noise_3d: lattice writes and noise
// evaluations are driven through valid/ready channels and every result is
// compared with a directed value or an in-bench predictor. Depends on ovn_pkg and the ovn_*_if interfaces.
`timescale 1ns / 1ps

module tb_top;
  import ovn_pkg::*;

  localparam int LATTICE_SIZE    = 4096;
  localparam int Y_SHIFT         = 4;
  localparam int Z_SHIFT         = 8;
  localparam int FADE_SIZE       = 256;
  localparam int PREDICT         = -1;     // row expectation comes from the predictor
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 175;    // input transfers per phase, corner fills included
  localparam int SETTLE_CYCLES   = 160;
  localparam int HOLD_AT         = 60;     // result count that starts the long hold-off
  localparam int HOLD_CYCLES     = 2500;
  localparam int CALM_PHASE      = 3;

  // Register indexes outside the map; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 4'd15;

  typedef struct {
    cmd_t        cmd;
    logic [11:0] idx;
    logic [15:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    int          want;
  } step_t;

  logic clk;
  logic rst_n;

  ovn_in_if  in_chan ();
  ovn_out_if out_chan ();
  ovn_cfg_if cfg_chan ();

  octave_value_noise_3d dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predictor state
  logic [15:0]  lattice_model [LATTICE_SIZE];
  bit           lattice_set   [LATTICE_SIZE];
  logic [15:0]  fade_lut      [FADE_SIZE];
  logic [4:0]   oct_cfg;
  logic [15:0]  falloff_cfg;
  logic [11:0]  oct_base [16];
  logic [15:0]  oct_wx   [16];
  logic [15:0]  oct_wy   [16];
  logic [15:0]  oct_wz   [16];

  logic [15:0]  expected_noise [$];
  step_t        script [$];
  bit           calm = 1'b0;
  int           fail_count = 0;
  int           sent_count = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop for a hung block
  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

  // Cosine fade weight for one ROM slot: Taylor sine in Q2.30, squared, to Q0.16
  function automatic logic [15:0] fade_entry(int unsigned slot);
    longint unsigned ang, ang2, term, acc, sq, w, div;
    ang  = (64'd3373259426 * slot) / (2 * FADE_SIZE);
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = ang;
    for (int k = 1; k <= 7; k++) begin
      div  = longint'(2 * k) * longint'(2 * k + 1);
      term = ((term * ang2) >> 30) / div;
      if (k % 2 == 1) acc = (term > acc) ? 64'd0 : acc - term;
      else acc = acc + term;
    end
    sq = (acc * acc) >> 30;
    w  = (sq + 64'd8192) >> 14;
    return (w > 64'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [31:0] abs_coord(logic [31:0] v);
    if (v == 32'h8000_0000) return 32'h7FFF_FFFF;
    if (v[31]) return ~v + 32'd1;
    return v;
  endfunction

  // Offset of corner k (bit 0: +x, bit 1: +y, bit 2: +z)
  function automatic logic [11:0] corner_ofs(int k);
    return (12'(k & 1)) | (12'((k >> 1) & 1) << Y_SHIFT) | (12'((k >> 2) & 1) << Z_SHIFT);
  endfunction

  function automatic logic [15:0] mix(logic [15:0] a, logic [15:0] b, logic [15:0] w);
    longint unsigned v;
    v = longint'(a) * (64'd65536 - longint'(w)) + longint'(b) * longint'(w) + 64'd32768;
    return v[31:16];
  endfunction

  // Fill per-octave lattice base and fade weights; return the octave count used
  function automatic int walk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] mx, my, mz;
    int          n;
    mx = abs_coord(x);
    my = abs_coord(y);
    mz = abs_coord(z);
    n  = (oct_cfg > MAX_OCTAVES) ? int'(MAX_OCTAVES) : int'(oct_cfg);
    for (int o = 0; o < n; o++) begin
      oct_base[o] = mx[27:16] + {my[23:16], 4'b0000} + {mz[19:16], 8'h00};
      oct_wx[o]   = fade_lut[mx[15:8]];
      oct_wy[o]   = fade_lut[my[15:8]];
      oct_wz[o]   = fade_lut[mz[15:8]];
      // double: only the low integer bits reach the offset, so the lost top bit is harmless
      mx = mx << 1;
      my = my << 1;
      mz = mz << 1;
    end
    return n;
  endfunction

  function automatic logic [15:0] predict_noise(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z);
    int              n;
    longint unsigned acc, amp;
    logic [15:0]     c [8];
    logic [15:0]     lo, hi;
    logic [11:0]     a;
    n   = walk_point(x, y, z);
    acc = 0;
    amp = longint'(AMP_INIT);
    for (int o = 0; o < n; o++) begin
      for (int k = 0; k < 8; k++) begin
        a    = oct_base[o] + corner_ofs(k);
        c[k] = lattice_model[a];
      end
      lo  = mix(mix(c[0], c[1], oct_wx[o]), mix(c[2], c[3], oct_wx[o]), oct_wy[o]);
      hi  = mix(mix(c[4], c[5], oct_wx[o]), mix(c[6], c[7], oct_wx[o]), oct_wy[o]);
      acc = acc + longint'(mix(lo, hi, oct_wz[o])) * amp;
      amp = (amp * longint'(falloff_cfg) + 64'd32768) >> 16;
    end
    acc = (acc + 64'd32768) >> 16;
    return (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
  endfunction

  function automatic void add_step(cmd_t cmd, logic [11:0] idx, logic [15:0] val,
                                   logic [31:0] x, logic [31:0] y, logic [31:0] z, int want);
    script.push_back('{cmd, idx, val, x, y, z, want});
  endfunction

  // Offer one item and hold it until the transfer; record it in the predictor
  task automatic send_item(cmd_t cmd, logic [11:0] idx, logic [15:0] val,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z, int want);
    while (!calm && $urandom_range(99) < 16) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.command     <= cmd;
    in_chan.table_index <= idx;
    in_chan.table_value <= val;
    in_chan.coord_x     <= x;
    in_chan.coord_y     <= y;
    in_chan.coord_z     <= z;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_count++;
    if (cmd == CMD_WRITE) begin
      lattice_model[idx] = val;
      lattice_set[idx]   = 1'b1;
    end else if (want >= 0) begin
      expected_noise.push_back(16'(want));
    end else begin
      expected_noise.push_back(predict_noise(x, y, z));
    end
  endtask

  // Write any lattice corner the evaluation will read that has not been written yet
  task automatic fill_corners(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int          n;
    logic [11:0] a;
    n = walk_point(x, y, z);
    for (int o = 0; o < n; o++) begin
      for (int k = 0; k < 8; k++) begin
        a = oct_base[o] + corner_ofs(k);
        if (!lattice_set[a])
          send_item(CMD_WRITE, a, 16'($urandom_range(65535)), $urandom, $urandom, $urandom,
                    PREDICT);
      end
    end
  endtask

  task automatic eval_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, int want);
    fill_corners(x, y, z);
    send_item(CMD_EVAL, 12'($urandom_range(4095)), 16'($urandom_range(65535)), x, y, z, want);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    if (idx == CFG_OCTAVE_COUNT) oct_cfg = data[4:0];
    else if (idx == CFG_AMP_FALLOFF) falloff_cfg = data;
  endtask

  // Drain: stop offering, wait for every result, then let a trailing write finish
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_noise.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int ph);
    case (ph)
      0: begin
        write_reg(CFG_OCTAVE_COUNT, 16'hFFF0);  // masks to 16
        write_reg(CFG_AMP_FALLOFF, 16'hFFFF);   // sum saturates
      end
      1: begin
        write_reg(CFG_OCTAVE_COUNT, 16'h0001);
        write_reg(CFG_AMP_FALLOFF, 16'h0000);
        write_reg(CFG_IDX_TOP, 16'hFFFF);
        write_reg(CFG_IDX_SPARE, 16'h0001);
      end
      2: begin
        write_reg(CFG_OCTAVE_COUNT, 16'h0020);  // masks to zero octaves
        write_reg(CFG_AMP_FALLOFF, 16'h1234);
      end
      3: begin
        write_reg(CFG_OCTAVE_COUNT, 16'h001F);  // above 16, saturates
        write_reg(CFG_AMP_FALLOFF, 16'h8000);
      end
      default: begin
        write_reg(CFG_OCTAVE_COUNT, 16'($urandom_range(65535)));
        write_reg(CFG_AMP_FALLOFF, 16'($urandom_range(65535)));
      end
    endcase
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h0001_0000;
          default: v = 32'h0000_FFFF;
        endcase
      end
      1, 2: v = $urandom;
      default: begin
        v = $urandom_range(32'h003F_FFFF);
        if ($urandom_range(1)) v = ~v + 32'd1;
      end
    endcase
    return v;
  endfunction

  // Result side: check each transfer, stall at random, and hold off once for a long stretch
  initial begin : result_sink
    int          hold_left;
    int          seen;
    bit          held;
    logic [15:0] want;
    hold_left = 0;
    seen      = 0;
    held      = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        seen++;
        if (expected_noise.size() == 0) begin
          $error("noise_value: expected none, actual %0d", out_chan.noise_value);
          fail_count++;
        end else begin
          want = expected_noise.pop_front();
          if (out_chan.noise_value !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, out_chan.noise_value);
            fail_count++;
          end
        end
        if (seen == HOLD_AT && !held) begin
          held      = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] x, y, z;
    int          phase_end;
    for (int i = 0; i < FADE_SIZE; i++) fade_lut[i] = fade_entry(i);
    oct_cfg     = MAX_OCTAVES;
    falloff_cfg = FALLOFF_INIT;

    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.command     <= CMD_WRITE;
    in_chan.table_index <= '0;
    in_chan.table_value <= '0;
    in_chan.coord_x     <= '0;
    in_chan.coord_y     <= '0;
    in_chan.coord_z     <= '0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.index      <= CFG_OCTAVE_COUNT;
    cfg_chan.data       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows at reset settings (16 octaves, falloff one half).
    // Origin corners all full scale: amplitudes sum to 65535, so 65535 * 65535 rounds to 65534.
    for (int k = 0; k < 8; k++) add_step(CMD_WRITE, corner_ofs(k), 16'hFFFF, 0, 0, 0, PREDICT);
    add_step(CMD_EVAL,  12'd0,    16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 65534);
    // Origin corners all zero: nothing to sum
    for (int k = 0; k < 8; k++) add_step(CMD_WRITE, corner_ofs(k), 16'h0000, 0, 0, 0, PREDICT);
    add_step(CMD_EVAL,  12'd0,    16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
    // Most negative coordinate, largest coordinate, mixed signs and full fractions
    add_step(CMD_EVAL,  12'hFFF,  16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             PREDICT);
    add_step(CMD_EVAL,  12'h000,  16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             PREDICT);
    add_step(CMD_EVAL,  12'h555,  16'hAAAA, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_FFFF,
             PREDICT);
    add_step(CMD_EVAL,  12'hAAA,  16'h5555, 32'h7FFF_0000, 32'h8001_0000, 32'h0000_8000,
             PREDICT);
    add_step(CMD_WRITE, 12'hFFF,  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             PREDICT);
    add_step(CMD_WRITE, 12'hAAA,  16'h5555, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
             PREDICT);
    foreach (script[i]) begin
      if (script[i].cmd == CMD_EVAL)
        eval_point(script[i].x, script[i].y, script[i].z, script[i].want);
      else
        send_item(script[i].cmd, script[i].idx, script[i].val, script[i].x, script[i].y,
                  script[i].z, script[i].want);
    end

    // Random phases, each under its own register setting and its own transfer budget
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = 1'b0;
      settle();
      configure(ph);
      calm = (ph == CALM_PHASE);
      phase_end = sent_count + ITEMS_PER_PHASE;
      while (sent_count < phase_end) begin
        if ($urandom_range(99) < 35) begin
          send_item(CMD_WRITE, 12'($urandom_range(4095)), 16'($urandom_range(65535)),
                    $urandom, $urandom, $urandom, PREDICT);
        end else begin
          x = pick_coord();
          y = pick_coord();
          z = pick_coord();
          eval_point(x, y, z, PREDICT);
        end
      end
    end
    calm = 1'b0;
    settle();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
